// File: rtl/wmdu_pkg.sv
// Package with shared types and constants for the multiply/divide unit.
`default_nettype none
package wmdu_pkg;

  localparam int unsigned NUM_REGS = 6;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned CNT_W    = 5;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic [IDX_W-1:0] REG_A0 = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_A1 = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_A2 = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_A3 = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_B0 = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_B1 = IDX_W'(5);

  localparam logic [IDX_W-1:0] REG_IDX_LAST = IDX_W'(NUM_REGS - 1);

  localparam logic [CNT_W-1:0] DIV16_LAST = CNT_W'(15);
  localparam logic [CNT_W-1:0] DIV32_LAST = CNT_W'(31);

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_MUL   = 2'd1,
    OP_DIV16 = 2'd2,
    OP_DIV32 = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    SEQ_IDLE  = 4'd0,
    SEQ_0     = 4'd1,
    SEQ_04    = 4'd2,
    SEQ_041   = 4'd3,
    SEQ_01    = 4'd4,
    SEQ_014   = 4'd5,
    SEQ_012   = 4'd6,
    SEQ_0123  = 4'd7,
    SEQ_01234 = 4'd8
  } seq_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_WB   = 2'd2
  } state_e;

  typedef struct packed {
    logic capture;
    logic load;
    logic step;
    logic wb;
    op_e  op;
  } cmd_t;

endpackage
`default_nettype wire

// File: rtl/wide_mul_div_unit_top.sv
// Top level of the multiply/divide unit: controller and datapath.
// Each transaction is one byte read or write of six data registers and gives one
// result. Reads and plain writes add no hold-off of their own. The write that completes a
// multiply sequence (0,4,1,5) holds off the next transaction while the 16x16 product
// is written back. The write that completes a 16/16 divide (0,1,4,5) or a 32/16
// divide (0,1,2,3,4,5) runs a restoring divider one quotient bit per cycle, so the next
// transaction waits until the quotient and remainder have been written back.
// The result of the starting write is shown at once and can be taken while the
// operation runs. Division by zero gives an all-ones quotient and the low 16
// bits of the dividend as remainder.
`default_nettype none
module wide_mul_div_unit_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       command_i,
  input  logic [2:0] reg_index_i,
  input  logic [7:0] write_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_byte_o,
  output logic [1:0] started_op_o
);
  import wmdu_pkg::*;

  cmd_t cmd;
  op_e  start_op;

  wmdu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .start_op_i  (start_op),
    .cmd_o       (cmd)
  );

  wmdu_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .command_i    (command_i),
    .reg_index_i  (reg_index_i),
    .write_byte_i (write_byte_i),
    .cmd_i        (cmd),
    .start_op_o   (start_op),
    .read_byte_o  (read_byte_o),
    .started_op_o (started_op_o)
  );

endmodule
`default_nettype wire

// File: rtl/wmdu_ctrl.sv
// Controller state machine: handshake, operation sequencing and step counting.
`default_nettype none
module wmdu_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  wmdu_pkg::op_e start_op_i,
  output wmdu_pkg::cmd_t cmd_o
);
  import wmdu_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  op_e              op_q, op_d;
  logic             out_valid_q, out_valid_d;
  logic             in_accept;
  logic             out_accept;

  assign in_stall_o  = (state_q != ST_IDLE) | (out_valid_q & out_stall_i);
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign out_accept  = out_valid_q & ~out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (start_op_i)
            OP_MUL:           state_d = ST_WB;
            OP_DIV16, OP_DIV32: state_d = ST_DIV;
            default:          state_d = ST_IDLE;
          endcase
        end
      end
      ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = ST_WB;
        end
      end
      ST_WB:   state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.capture = in_accept;
    cmd_o.load    = in_accept & ((start_op_i == OP_DIV16) | (start_op_i == OP_DIV32));
    cmd_o.step    = (state_q == ST_DIV);
    cmd_o.wb      = (state_q == ST_WB);
    cmd_o.op      = op_q;
  end

  always_comb begin
    cnt_d = cnt_q;
    op_d  = op_q;
    if (in_accept) begin
      op_d  = start_op_i;
      cnt_d = (start_op_i == OP_DIV32) ? DIV32_LAST : DIV16_LAST;
    end else if (state_q == ST_DIV) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (out_accept) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      op_q        <= OP_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> state_q == ST_IDLE)
    else $error("transaction accepted while an operation runs");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q != '0) |=> (state_q == ST_DIV && cnt_q == $past(cnt_q) - CNT_W'(1)))
    else $error("divide step count did not advance");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && start_op_i != OP_NONE) |=> state_q != ST_IDLE)
    else $error("started operation did not leave idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_accept))
    else $error("result shown without an accepted transaction");

endmodule
`default_nettype wire

// File: rtl/wmdu_datapath.sv
// Datapath: byte registers, write sequence tracking, multiplier and serial divider.
`default_nettype none
module wmdu_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      command_i,
  input  logic [wmdu_pkg::IDX_W-1:0] reg_index_i,
  input  logic [7:0]                write_byte_i,
  input  wmdu_pkg::cmd_t            cmd_i,
  output wmdu_pkg::op_e             start_op_o,
  output logic [7:0]                read_byte_o,
  output logic [1:0]                started_op_o
);
  import wmdu_pkg::*;

  logic [7:0]  data_q [NUM_REGS];
  seq_e        seq_q, seq_d;
  op_e         op_dec;
  logic [31:0] acc_q;
  logic [15:0] rem_q;
  logic [7:0]  read_byte_q;
  op_e         started_op_q;
  logic        idx_ok;
  logic        is_write;
  logic [15:0] divisor;
  logic [16:0] shifted;
  logic [16:0] diff;
  logic        ge;
  logic [31:0] product;

  assign idx_ok   = (reg_index_i <= REG_IDX_LAST);
  assign is_write = (command_i == CMD_WRITE);
  assign divisor  = {data_q[REG_B1], data_q[REG_B0]};
  assign shifted  = {rem_q, acc_q[31]};
  assign diff     = shifted - {1'b0, divisor};
  assign ge       = (shifted >= {1'b0, divisor});
  assign product  = 32'({data_q[REG_A1], data_q[REG_A0]}) * 32'(divisor);

  always_comb begin
    seq_d  = seq_q;
    op_dec = OP_NONE;
    if (is_write) begin
      seq_d = SEQ_IDLE;
      unique case (reg_index_i)
        REG_A0: seq_d = SEQ_0;
        REG_A1: begin
          if (seq_q == SEQ_0) begin
            seq_d = SEQ_01;
          end else if (seq_q == SEQ_04) begin
            seq_d = SEQ_041;
          end
        end
        REG_A2: begin
          if (seq_q == SEQ_01) begin
            seq_d = SEQ_012;
          end
        end
        REG_A3: begin
          if (seq_q == SEQ_012) begin
            seq_d = SEQ_0123;
          end
        end
        REG_B0: begin
          if (seq_q == SEQ_0) begin
            seq_d = SEQ_04;
          end else if (seq_q == SEQ_01) begin
            seq_d = SEQ_014;
          end else if (seq_q == SEQ_0123) begin
            seq_d = SEQ_01234;
          end
        end
        REG_B1: begin
          if (seq_q == SEQ_041) begin
            op_dec = OP_MUL;
          end else if (seq_q == SEQ_014) begin
            op_dec = OP_DIV16;
          end else if (seq_q == SEQ_01234) begin
            op_dec = OP_DIV32;
          end
        end
        default: seq_d = SEQ_IDLE;
      endcase
    end
  end

  assign start_op_o = op_dec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= SEQ_IDLE;
      for (int i = 0; i < NUM_REGS; i++) begin
        data_q[i] <= '0;
      end
    end else begin
      if (cmd_i.capture) begin
        seq_q <= seq_d;
        if (is_write && idx_ok) begin
          data_q[reg_index_i] <= write_byte_i;
        end
      end
      if (cmd_i.wb) begin
        unique case (cmd_i.op)
          OP_MUL: begin
            data_q[REG_A0] <= product[7:0];
            data_q[REG_A1] <= product[15:8];
            data_q[REG_A2] <= product[23:16];
            data_q[REG_A3] <= product[31:24];
          end
          OP_DIV16: begin
            data_q[REG_A0] <= acc_q[7:0];
            data_q[REG_A1] <= acc_q[15:8];
            data_q[REG_B0] <= rem_q[7:0];
            data_q[REG_B1] <= rem_q[15:8];
          end
          OP_DIV32: begin
            data_q[REG_A0] <= acc_q[7:0];
            data_q[REG_A1] <= acc_q[15:8];
            data_q[REG_A2] <= acc_q[23:16];
            data_q[REG_A3] <= acc_q[31:24];
            data_q[REG_B0] <= rem_q[7:0];
            data_q[REG_B1] <= rem_q[15:8];
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q <= '0;
      if (op_dec == OP_DIV32) begin
        acc_q <= {data_q[REG_A3], data_q[REG_A2], data_q[REG_A1], data_q[REG_A0]};
      end else begin
        acc_q <= {data_q[REG_A1], data_q[REG_A0], 16'h0000};
      end
    end else if (cmd_i.step) begin
      rem_q <= ge ? diff[15:0] : shifted[15:0];
      acc_q <= {acc_q[30:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      read_byte_q  <= (!is_write && idx_ok) ? data_q[reg_index_i] : 8'h00;
      started_op_q <= op_dec;
    end
  end

  assign read_byte_o  = read_byte_q;
  assign started_op_o = started_op_q;

endmodule
`default_nettype wire

// File: test/testbench.sv
// Testbench for wide_mul_div_unit_top: random byte accesses checked against a behavioral model.
`timescale 1ns / 100ps
module testbench;
  import wmdu_pkg::*;

  localparam logic [2:0] REG_BAD_LO = 3'd6;
  localparam logic [2:0] REG_BAD_HI = 3'd7;

  localparam int RANDOM_ACCESSES = 1850;
  localparam int HOLD_CYCLES     = 120;

  typedef struct packed {
    logic       cmd;
    logic [2:0] idx;
    logic [7:0] wbyte;
  } access_t;

  typedef struct packed {
    logic [7:0] read_byte;
    op_e        op;
  } reply_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic       command_i = CMD_WRITE;
  logic [2:0] reg_index_i = REG_A0;
  logic [7:0] write_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] read_byte_o;
  logic [1:0] started_op_o;

  access_t bus_accesses[$];
  reply_t  predicted_replies[$];

  logic [7:0] data_q[NUM_REGS];
  seq_e       seq_q = SEQ_IDLE;

  int err_count = 0;
  int replies_seen = 0;
  int op_count[4] = '{0, 0, 0, 0};
  int zero_div_count = 0;
  int gap_left = 0;
  int items_sent = 0;
  int stall_left = 0;
  int hold_left = 0;
  int hold_count = 0;
  int next_hold_at = 400;
  access_t cur_acc;
  reply_t  cur_reply;
  reply_t  want;

  wide_mul_div_unit_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .reg_index_i  (reg_index_i),
    .write_byte_i (write_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_byte_o  (read_byte_o),
    .started_op_o (started_op_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    foreach (data_q[i]) data_q[i] = 8'h00;
  end

  task automatic queue_access(input logic cmd, input logic [2:0] idx, input logic [7:0] wb);
    bus_accesses.push_back({cmd, idx, wb});
  endtask

  function automatic logic [7:0] operand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Apply one access to the modeled register file and sequence tracker.
  task automatic mdu_access(input access_t acc, output reply_t res);
    logic [15:0] divisor;
    logic [15:0] quot16;
    logic [31:0] dividend;
    logic [31:0] quot32;
    logic [31:0] product;
    seq_e        nxt;
    op_e         op;
    res.read_byte = 8'h00;
    op = OP_NONE;
    if (acc.cmd == CMD_READ) begin
      if (acc.idx <= REG_IDX_LAST) res.read_byte = data_q[acc.idx];
    end else if (acc.idx > REG_IDX_LAST) begin
      seq_q = SEQ_IDLE;
    end else begin
      data_q[acc.idx] = acc.wbyte;
      if (acc.idx == REG_A0) begin
        seq_q = SEQ_0;
      end else begin
        nxt = SEQ_IDLE;
        case (acc.idx)
          REG_A1: begin
            if (seq_q == SEQ_0) nxt = SEQ_01;
            else if (seq_q == SEQ_04) nxt = SEQ_041;
          end
          REG_A2: if (seq_q == SEQ_01) nxt = SEQ_012;
          REG_A3: if (seq_q == SEQ_012) nxt = SEQ_0123;
          REG_B0: begin
            if (seq_q == SEQ_0) nxt = SEQ_04;
            else if (seq_q == SEQ_01) nxt = SEQ_014;
            else if (seq_q == SEQ_0123) nxt = SEQ_01234;
          end
          REG_B1: begin
            if (seq_q == SEQ_041) op = OP_MUL;
            else if (seq_q == SEQ_014) op = OP_DIV16;
            else if (seq_q == SEQ_01234) op = OP_DIV32;
          end
          default: nxt = SEQ_IDLE;
        endcase
        seq_q = nxt;
        divisor = {data_q[REG_B1], data_q[REG_B0]};
        case (op)
          OP_MUL: begin
            product = {16'h0000, data_q[REG_A1], data_q[REG_A0]} * {16'h0000, divisor};
            {data_q[REG_A3], data_q[REG_A2], data_q[REG_A1], data_q[REG_A0]} = product;
          end
          OP_DIV16: begin
            dividend = {16'h0000, data_q[REG_A1], data_q[REG_A0]};
            if (divisor == 16'h0000) begin
              zero_div_count++;
              {data_q[REG_B1], data_q[REG_B0]} = dividend[15:0];
              {data_q[REG_A1], data_q[REG_A0]} = 16'hFFFF;
            end else begin
              quot16 = dividend[15:0] / divisor;
              {data_q[REG_B1], data_q[REG_B0]} = dividend[15:0] % divisor;
              {data_q[REG_A1], data_q[REG_A0]} = quot16;
            end
          end
          OP_DIV32: begin
            dividend = {data_q[REG_A3], data_q[REG_A2], data_q[REG_A1], data_q[REG_A0]};
            if (divisor == 16'h0000) begin
              zero_div_count++;
              {data_q[REG_B1], data_q[REG_B0]} = dividend[15:0];
              quot32 = 32'hFFFF_FFFF;
            end else begin
              quot32 = dividend / {16'h0000, divisor};
              {data_q[REG_B1], data_q[REG_B0]} = 16'(dividend % {16'h0000, divisor});
            end
            {data_q[REG_A3], data_q[REG_A2], data_q[REG_A1], data_q[REG_A0]} = quot32;
          end
          default: ;
        endcase
      end
    end
    res.op = op;
  endtask

  // Driver: present queued accesses with random gaps between them.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      command_i    <= CMD_WRITE;
      reg_index_i  <= REG_A0;
      write_byte_i <= 8'h00;
      gap_left = 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (gap_left != 0 || bus_accesses.size() == 0) begin
        if (gap_left != 0) gap_left--;
        in_valid_i <= 1'b0;
      end else begin
        cur_acc = bus_accesses.pop_front();
        in_valid_i   <= 1'b1;
        command_i    <= cur_acc.cmd;
        reg_index_i  <= cur_acc.idx;
        write_byte_i <= cur_acc.wbyte;
        gap_left = ((items_sent / 150) % 4 == 3) ? 0 : $urandom_range(0, 3);
        items_sent++;
      end
    end
  end

  // Long receiver hold-off so the block backs up and stalls its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (replies_seen == next_hold_at) begin
      hold_left    <= HOLD_CYCLES;
      next_hold_at <= next_hold_at + 900;
      hold_count   <= hold_count + 1;
    end
  end

  // Receiver: random stalls after each result.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        stall_left = ((replies_seen / 200) % 3 == 1) ? 0 : $urandom_range(0, 3);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left != 0) || (hold_left > 1);
    end
  end

  // Monitor: predict on each accepted access, check each accepted result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        mdu_access({command_i, reg_index_i, write_byte_i}, cur_reply);
        predicted_replies.push_back(cur_reply);
      end
      if (out_valid_o && !out_stall_i) begin
        if (predicted_replies.size() == 0) begin
          $error("result with no transaction pending: read_byte %02h started_op %0d",
                 read_byte_o, started_op_o);
          err_count++;
        end else begin
          want = predicted_replies.pop_front();
          if (read_byte_o !== want.read_byte) begin
            $error("read_byte: expected %02h, actual %02h", want.read_byte, read_byte_o);
            err_count++;
          end
          if (started_op_o !== want.op) begin
            $error("started_op: expected %0d, actual %0d", want.op, started_op_o);
            err_count++;
          end
        end
        if (!$isunknown(started_op_o)) op_count[started_op_o]++;
        replies_seen <= replies_seen + 1;
      end
    end
  end

  initial begin
    logic [2:0] order[6];
    int         len;
    int         cut;
    int         kind;
    int         n;
    logic       broken;
    logic       zero_div;
    logic [2:0] idx;

    queue_access(CMD_READ,  REG_BAD_HI, 8'hA5);
    queue_access(CMD_WRITE, REG_A0, 8'hFF);
    queue_access(CMD_WRITE, REG_B0, 8'hFF);
    queue_access(CMD_READ,  REG_A2, 8'h00);
    queue_access(CMD_WRITE, REG_A1, 8'hFF);
    queue_access(CMD_WRITE, REG_B1, 8'hFF);
    queue_access(CMD_READ,  REG_A3, 8'hFF);
    queue_access(CMD_WRITE, REG_A0, 8'h34);
    queue_access(CMD_WRITE, REG_A1, 8'h12);
    queue_access(CMD_WRITE, REG_B0, 8'h00);
    queue_access(CMD_WRITE, REG_B1, 8'h00);
    queue_access(CMD_WRITE, REG_A0, 8'hFF);
    queue_access(CMD_WRITE, REG_A0, 8'hEE);
    queue_access(CMD_WRITE, REG_A1, 8'hFF);
    queue_access(CMD_WRITE, REG_A2, 8'hFF);
    queue_access(CMD_WRITE, REG_A3, 8'hFF);
    queue_access(CMD_WRITE, REG_B0, 8'h01);
    queue_access(CMD_WRITE, REG_B1, 8'h00);
    queue_access(CMD_WRITE, REG_A0, 8'h78);
    queue_access(CMD_WRITE, REG_A1, 8'h56);
    queue_access(CMD_WRITE, REG_A2, 8'h34);
    queue_access(CMD_WRITE, REG_A3, 8'h12);
    queue_access(CMD_WRITE, REG_B0, 8'h00);
    queue_access(CMD_WRITE, REG_B1, 8'h00);
    queue_access(CMD_WRITE, REG_A2, 8'hAA);
    queue_access(CMD_WRITE, REG_BAD_LO, 8'h55);

    n = bus_accesses.size() + RANDOM_ACCESSES;
    while (bus_accesses.size() < n) begin
      kind = $urandom_range(0, 9);
      broken = ($urandom_range(0, 5) == 0);
      zero_div = ($urandom_range(0, 7) == 0);
      if (kind <= 2) begin
        order = '{REG_A0, REG_B0, REG_A1, REG_B1, REG_A0, REG_A0};
        len = 4;
      end else if (kind <= 4) begin
        order = '{REG_A0, REG_A1, REG_B0, REG_B1, REG_A0, REG_A0};
        len = 4;
      end else begin
        order = '{REG_A0, REG_A1, REG_A2, REG_A3, REG_B0, REG_B1};
        len = 6;
      end
      if (kind >= 8) begin
        repeat ($urandom_range(1, 3))
          queue_access(1'($urandom), 3'($urandom), 8'($urandom));
      end else begin
        cut = $urandom_range(1, len - 1);
        for (int i = 0; i < len; i++) begin
          if (broken && i == cut)
            queue_access(CMD_WRITE, 3'($urandom), 8'($urandom));
          if ($urandom_range(0, 7) == 0)
            queue_access(CMD_READ, 3'($urandom), 8'($urandom));
          idx = order[i];
          queue_access(CMD_WRITE, idx,
                       (zero_div && (idx == REG_B0 || idx == REG_B1)) ? 8'h00 : operand_byte());
        end
        repeat ($urandom_range(0, 3))
          queue_access(CMD_READ, 3'($urandom_range(0, NUM_REGS - 1)), 8'($urandom));
      end
    end

    while (bus_accesses.size() != 0 || in_valid_i || predicted_replies.size() != 0)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("summary: %0d transactions checked; started %0d multiplies, %0d 16/16 divides,",
             replies_seen, op_count[OP_MUL], op_count[OP_DIV16]);
    $display("summary: %0d 32/16 divides, %0d divides by zero, %0d long receiver hold-offs",
             op_count[OP_DIV32], zero_div_count, hold_count);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
